// ----- design/imm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants for the integer matrix multiply cell array.
// ----------------------------------------------------------------------------
package imm_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;
	localparam int DIM_W  = 4;

	typedef enum logic [1:0] {
		CFG_ROWS_A     = 2'd0,
		CFG_INNER_SIZE = 2'd1,
		CFG_COLS_B     = 2'd2
	} cfg_reg_t;

	// A element travelling along the cell row
	typedef struct packed {
		logic              v;
		logic              first;
		logic              lastk;
		logic [IDX_W-1:0]  kk;
		logic [IDX_W-1:0]  row;
		logic [DATA_W-1:0] a;
	} imm_beat_t;

	// B element write, broadcast to all cells
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] data;
	} imm_bwr_t;

endpackage
`default_nettype wire

// ----- design/imm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imm_cell
// One column cell: keeps a column of B, multiplies the passing A element by
// its B entry and accumulates one element of C.
// ----------------------------------------------------------------------------
module imm_cell
	import imm_pkg::*;
#(
	parameter int COL = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire imm_bwr_t          bwr,
	input  wire imm_beat_t         beat_in,
	output imm_beat_t              beat_out,
	output logic                   done,
	output logic [IDX_W-1:0]       done_row,
	output logic [DATA_W-1:0]      acc
);

	localparam logic [IDX_W-1:0] COL_IDX = IDX_W'(COL);

	logic [DATA_W-1:0]   bmem [0:(1<<IDX_W)-1];
	logic [DATA_W-1:0]   b_rd_s1;
	imm_beat_t           beat_s1;
	logic [DATA_W-1:0]   mul_lo;
	logic [DATA_W-1:0]   prod_s2;
	logic                v_s2, first_s2, lastk_s2;
	logic [IDX_W-1:0]    row_s2;
	logic [DATA_W-1:0]   acc_q;
	logic                done_q;
	logic [IDX_W-1:0]    row_q;

	always_ff @(posedge clk) begin
		if (bwr.we && bwr.col == COL_IDX) begin
			bmem[bwr.row] <= bwr.data;
		end
		b_rd_s1 <= bmem[beat_in.kk];
	end

	// low word only: the product wraps modulo 2^32
	assign mul_lo = beat_s1.a * b_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			beat_s1 <= beat_in;
			v_s2    <= beat_s1.v;
			done_q  <= v_s2 & lastk_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2  <= mul_lo;
		first_s2 <= beat_s1.first;
		lastk_s2 <= beat_s1.lastk;
		row_s2   <= beat_s1.row;
		row_q    <= row_s2;
		if (v_s2) begin
			// restart the dot product on the first term, wrap modulo 2^32
			acc_q <= first_s2 ? prod_s2 : acc_q + prod_s2;
		end
	end

	assign beat_out = beat_s1;
	assign done     = done_q;
	assign done_row = row_q;
	assign acc      = acc_q;

endmodule
`default_nettype wire

// ----- design/integer_matrix_multiply.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Loading: one element a cycle, busy low, until the last element of B, while
// start is high and no configuration write comes. Compute: A rows enter a row
// of MAX_DIM column cells one after another, starting after the last B beat;
// the results of a row come one per cycle.
// The single A store read port and the row spacing set the length of a pass.
// Reset clears load counters, busy and the result strobe; stores are not cleared.
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// C = A x B over signed 32-bit elements with a systolic row of column cells.
// ----------------------------------------------------------------------------
module integer_matrix_multiply
	import imm_pkg::*;
#(
	parameter int MAX_DIM = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [DATA_W-1:0] element,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [DIM_W-1:0]  cfg_data,
	output logic                   strobe,
	output logic [DATA_W-1:0]      product,
	output logic [IDX_W-1:0]       row,
	output logic [IDX_W-1:0]       col,
	output logic                   last
);

	localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0]  rows_a_q, inner_q, cols_q;
	logic [IDX_W-1:0]  rm1, km1, cm1, spm1;
	logic              phase_b_q;
	logic [IDX_W-1:0]  ld_row_q, ld_col_q;
	logic              busy_q, issuing_q;
	logic [IDX_W-1:0]  iss_row_q, iss_t_q;
	logic              acc_in, cfg_wr, ld_col_end, b_done;
	logic [DATA_W-1:0] amem [0:(1<<(2*IDX_W))-1];
	logic [DATA_W-1:0] a_rd_s1;
	logic              iss_v_s1;
	logic [IDX_W-1:0]  kk_s1, row_s1;
	imm_bwr_t          bwr;
	imm_beat_t         beat [0:MAX_DIM];
	logic [MAX_DIM-1:0] cell_done;
	logic [MAX_DIM-1:0] col_live;
	logic [IDX_W-1:0]  cell_row [0:MAX_DIM-1];
	logic [DATA_W-1:0] cell_acc [0:MAX_DIM-1];
	logic              sel_v;
	logic [DATA_W-1:0] sel_acc;
	logic [IDX_W-1:0]  sel_row, sel_col;
	logic              strobe_q, last_q;
	logic [DATA_W-1:0] product_q;
	logic [IDX_W-1:0]  row_q, col_q;

	function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_W-1:0] v,
	                                           input logic [DIM_W-1:0] mx);
		logic [DIM_W-1:0] t;
		begin
			t = (v == '0) ? DIM_W'(1) : ((v > mx) ? mx : v);
			dim_m1 = IDX_W'(t - DIM_W'(1));
		end
	endfunction

	assign rm1  = dim_m1(rows_a_q, MAX_D);
	assign km1  = dim_m1(inner_q, MAX_D);
	assign cm1  = dim_m1(cols_q, MAX_D);
	assign spm1 = (km1 > cm1) ? km1 : cm1;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid & cfg_ready;
	assign busy       = busy_q;
	assign acc_in     = start & ~busy_q;
	assign ld_col_end = phase_b_q ? (ld_col_q == cm1) : (ld_col_q == km1);
	assign b_done     = acc_in & phase_b_q & ld_col_end & (ld_row_q == km1);

	// configuration and load / issue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q  <= MAX_D;
			inner_q   <= MAX_D;
			cols_q    <= MAX_D;
			phase_b_q <= 1'b0;
			ld_row_q  <= '0;
			ld_col_q  <= '0;
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			iss_row_q <= '0;
			iss_t_q   <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_ROWS_A:     rows_a_q <= cfg_data;
					CFG_INNER_SIZE: inner_q  <= cfg_data;
					CFG_COLS_B:     cols_q   <= cfg_data;
					default: ;
				endcase
				// restart the pass on a known register only
				if (cfg_index == CFG_ROWS_A || cfg_index == CFG_INNER_SIZE ||
				    cfg_index == CFG_COLS_B) begin
					phase_b_q <= 1'b0;
					ld_row_q  <= '0;
					ld_col_q  <= '0;
				end
			end else if (acc_in) begin
				if (ld_col_end) begin
					ld_col_q <= '0;
					if (phase_b_q ? (ld_row_q == km1) : (ld_row_q == rm1)) begin
						ld_row_q  <= '0;
						phase_b_q <= ~phase_b_q;
					end else begin
						ld_row_q <= ld_row_q + IDX_W'(1);
					end
				end else begin
					ld_col_q <= ld_col_q + IDX_W'(1);
				end
			end

			if (b_done) begin
				busy_q    <= 1'b1;
				issuing_q <= 1'b1;
				iss_row_q <= '0;
				iss_t_q   <= '0;
			end else begin
				if (issuing_q) begin
					if (iss_t_q == spm1) begin
						iss_t_q <= '0;
						if (iss_row_q == rm1) begin
							issuing_q <= 1'b0;
						end else begin
							iss_row_q <= iss_row_q + IDX_W'(1);
						end
					end else begin
						iss_t_q <= iss_t_q + IDX_W'(1);
					end
				end
				if (sel_v && sel_row == rm1 && sel_col == cm1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// A store: write on A load beats, read one word a cycle on issue
	always_ff @(posedge clk) begin
		if (acc_in && !phase_b_q) begin
			amem[{ld_row_q, ld_col_q}] <= element;
		end
		a_rd_s1 <= amem[{iss_row_q, iss_t_q}];
		kk_s1   <= iss_t_q;
		row_s1  <= iss_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_v_s1 <= 1'b0;
		end else begin
			iss_v_s1 <= issuing_q & (iss_t_q <= km1);
		end
	end

	always_comb begin
		bwr.we   = acc_in & phase_b_q;
		bwr.row  = ld_row_q;
		bwr.col  = ld_col_q;
		bwr.data = element;

		beat[0].v     = iss_v_s1;
		beat[0].first = (kk_s1 == '0);
		beat[0].lastk = (kk_s1 == km1);
		beat[0].kk    = kk_s1;
		beat[0].row   = row_s1;
		beat[0].a     = a_rd_s1;
	end

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		imm_cell #(
			.COL(j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bwr      (bwr),
			.beat_in  (beat[j]),
			.beat_out (beat[j+1]),
			.done     (cell_done[j]),
			.done_row (cell_row[j]),
			.acc      (cell_acc[j])
		);

		assign col_live[j] = (IDX_W'(j) <= cm1);
	end

	// cells finish one after another, so at most one live column fires
	always_comb begin
		sel_v   = 1'b0;
		sel_acc = '0;
		sel_row = '0;
		sel_col = '0;
		for (int j = 0; j < MAX_DIM; j++) begin
			if (cell_done[j] && IDX_W'(j) <= cm1) begin
				sel_v   = 1'b1;
				sel_acc = cell_acc[j];
				sel_row = cell_row[j];
				sel_col = IDX_W'(j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= sel_v;
		end
	end

	always_ff @(posedge clk) begin
		product_q <= sel_acc;
		row_q     <= sel_row;
		col_q     <= sel_col;
		last_q    <= (sel_row == rm1) && (sel_col == cm1);
	end

	assign strobe  = strobe_q;
	assign product = product_q;
	assign row     = row_q;
	assign col     = col_q;
	assign last    = last_q;

	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_done & col_live & {MAX_DIM{busy_q}}))
		else $error("two cells completed in the same cycle");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat outside a compute pass");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("busy held after final result beat");

	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> busy_q)
		else $error("A rows issued while not busy");

endmodule
`default_nettype wire
